/* hdl/cop_pkg.sv */
// Shared types and constants for the clock offset pinner.
package cop_pkg;

	localparam int STAMP_BITS_DEF = 52;

	typedef enum logic [1:0] {
		KIND_VALID   = 2'd0,
		KIND_INVALID = 2'd1,
		KIND_NONE    = 2'd2
	} kind_t;

	typedef struct packed {
		logic fresh;
		logic known;
	} flags_t;

endpackage

/* hdl/cop_core.sv */
// Run tracking state, offset pinning and best estimate selection.
module cop_core #(
	parameter int STAMP_BITS = cop_pkg::STAMP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [STAMP_BITS-1:0]        stamp,
	input  logic                         from_invalid_clock,
	output cop_pkg::flags_t              flags_nxt,
	output logic signed [STAMP_BITS+1:0] offset_nxt,
	output logic [STAMP_BITS-1:0]        error_nxt
);

	localparam int SB = STAMP_BITS;

	logic [SB-1:0] low_v_q, high_v_q, low_i_q, high_i_q;
	cop_pkg::kind_t cur_q;
	logic have_q;
	logic signed [SB+1:0] offset_q;
	logic [SB-1:0] error_q;

	cop_pkg::kind_t kind;
	logic [SB-1:0] lo_k, hi_k, lo_o, hi_o;
	logic same, pin, take;
	logic [SB:0] sum_a, sum_b;
	logic signed [SB+1:0] diff, off;
	logic [SB-1:0] d1, d2, err;
	logic [SB-1:0] lo_k_nxt, hi_k_nxt;

	always_comb begin
		kind = from_invalid_clock ? cop_pkg::KIND_INVALID : cop_pkg::KIND_VALID;
		lo_k = from_invalid_clock ? low_i_q  : low_v_q;
		hi_k = from_invalid_clock ? high_i_q : high_v_q;
		lo_o = from_invalid_clock ? low_v_q  : low_i_q;
		hi_o = from_invalid_clock ? high_v_q : high_i_q;
		same = (cur_q == kind);

		sum_a = {1'b0, hi_k} + {1'b0, stamp};
		sum_b = {1'b0, lo_o} + {1'b0, hi_o};
		diff  = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});
		off   = from_invalid_clock ? -diff : diff;

		d1  = (stamp >= hi_k) ? stamp - hi_k : hi_k - stamp;
		d2  = (hi_o >= lo_o) ? hi_o - lo_o : lo_o - hi_o;
		err = (d1 >= d2) ? d1 - d2 : d2 - d1;

		pin  = !same && (lo_k != '0) && (lo_o != '0);
		take = pin && (!have_q || (err < error_q));

		flags_nxt.fresh = pin;
		flags_nxt.known = have_q | take;
		offset_nxt      = take ? off : offset_q;
		error_nxt       = take ? err : error_q;

		if (same) begin
			lo_k_nxt = (stamp < lo_k) ? stamp : lo_k;
			hi_k_nxt = (stamp > hi_k) ? stamp : hi_k;
		end else begin
			lo_k_nxt = stamp;
			hi_k_nxt = stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_v_q  <= '0;
			high_v_q <= '0;
			low_i_q  <= '0;
			high_i_q <= '0;
			cur_q    <= cop_pkg::KIND_NONE;
			have_q   <= 1'b0;
			offset_q <= '0;
			error_q  <= '0;
		end else if (step) begin
			if (from_invalid_clock) begin
				low_i_q  <= lo_k_nxt;
				high_i_q <= hi_k_nxt;
			end else begin
				low_v_q  <= lo_k_nxt;
				high_v_q <= hi_k_nxt;
			end
			cur_q    <= kind;
			have_q   <= flags_nxt.known;
			offset_q <= offset_nxt;
			error_q  <= error_nxt;
		end
	end

	a_have_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |=> have_q)
		else $error("estimate flag cleared");

	a_error_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |=> (error_q <= $past(error_q)))
		else $error("kept error grew");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(low_v_q <= high_v_q) && (low_i_q <= high_i_q))
		else $error("run low end above high end");

endmodule

/* hdl/clock_offset_pinner.sv */
// Top level of the clock offset pinner: handshake, input and result registers.
//
// Usage:
//   Input channel: stamp and from_invalid_clock, qualified by stamp_valid,
//   taken at an edge where stamp_valid is high and stamp_stall is low.
//   Result channel: new_estimate, offset_known, best_offset_doubled and
//   best_error_doubled, qualified by result_valid, taken when result_stall
//   is low. Every item gives exactly one result, in order.
//   An accepted item passes through the input register, then the result
//   register, which drives result_valid; the run state is updated as the item
//   enters the result register, so the next item sees it.
//   Throughput: one item per cycle while result_stall is low, limited only by
//   the add, subtract and compare path between input and result register.
//   Reset: arst_n clears both runs, the current run kind and the kept
//   estimate; no item or result is held afterwards.
//   Stall: while result_stall holds a waiting result, the input register
//   can still take one item; stamp_stall then rises until the result leaves.
module clock_offset_pinner #(
	parameter int STAMP_BITS = cop_pkg::STAMP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         stamp_valid,
	output logic                         stamp_stall,
	input  logic [STAMP_BITS-1:0]        stamp,
	input  logic                         from_invalid_clock,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         new_estimate,
	output logic                         offset_known,
	output logic signed [STAMP_BITS+1:0] best_offset_doubled,
	output logic [STAMP_BITS:0]          best_error_doubled
);

	logic valid_s1_q;
	logic [STAMP_BITS-1:0] stamp_s1;
	logic invalid_s1;
	logic valid_s2_q;
	cop_pkg::flags_t flags_s2;
	logic signed [STAMP_BITS+1:0] offset_s2;
	logic [STAMP_BITS-1:0] error_s2;

	logic accept, advance;
	cop_pkg::flags_t flags_nxt;
	logic signed [STAMP_BITS+1:0] offset_nxt;
	logic [STAMP_BITS-1:0] error_nxt;

	assign advance     = valid_s1_q && !(valid_s2_q && result_stall);
	assign stamp_stall = valid_s1_q && valid_s2_q && result_stall;
	assign accept      = stamp_valid && !stamp_stall;

	cop_core #(
		.STAMP_BITS(STAMP_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.stamp             (stamp_s1),
		.from_invalid_clock(invalid_s1),
		.flags_nxt         (flags_nxt),
		.offset_nxt        (offset_nxt),
		.error_nxt         (error_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1_q <= 1'b1;
			end else if (advance) begin
				valid_s1_q <= 1'b0;
			end
			if (advance) begin
				valid_s2_q <= 1'b1;
			end else if (!result_stall) begin
				valid_s2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_s1   <= stamp;
			invalid_s1 <= from_invalid_clock;
		end
		if (advance) begin
			flags_s2  <= flags_nxt;
			offset_s2 <= offset_nxt;
			error_s2  <= error_nxt;
		end
	end

	assign result_valid        = valid_s2_q;
	assign new_estimate        = flags_s2.fresh;
	assign offset_known        = flags_s2.known;
	assign best_offset_doubled = offset_s2;
	assign best_error_doubled  = {1'b0, error_s2};

	a_fresh_known: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2_q && flags_s2.fresh) |-> flags_s2.known)
		else $error("fresh estimate without a kept offset");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1_q)
		else $error("accepted item lost from input register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2_q && result_stall) |=> valid_s2_q)
		else $error("stalled result dropped");

endmodule
